>>> rtl/core/srpf_pkg.sv
// Package for the short-range pair force unit: formats, register codes,
// reset values and the control structs shared by the datapath units.
// No dependencies.
`default_nettype none
package srpf_pkg;

	localparam int FRAC_BITS = 24;
	localparam int POS_W     = 32;
	localparam int ACC_W     = 48;
	localparam int Q_W       = FRAC_BITS + 1;
	localparam int SUM_W     = 40;
	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_R    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_MASS = 2'd2;

	localparam logic [POS_W-1:0] CUTOFF_RESET = 32'd1593836;
	localparam logic [POS_W-1:0] MIN_R_RESET  = 32'd15938;
	localparam logic [POS_W-1:0] INV_M_RESET  = 32'd23967671;

	// divider geometry
	localparam int DIV_NUM_W = 128;
	localparam int DIV_DEN_W = 96;
	localparam int DIV_QUO_W = 64;
	localparam int DIV_CNT_W = 7;
	localparam logic [DIV_CNT_W-1:0] FORCE_STEPS = DIV_CNT_W'(ACC_W);
	localparam logic [DIV_CNT_W-1:0] RATIO_STEPS = DIV_CNT_W'(FRAC_BITS + 1);
	localparam logic [DIV_QUO_W-1:0] MAG_CAP     = DIV_QUO_W'(1) << (ACC_W - 1);

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/srpf_in_if.sv
// Input channel of the pair force unit: one particle pair per beat.
// Depends on srpf_pkg.
`default_nettype none
interface srpf_in_if import srpf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [POS_W-1:0]        particle_x;
	logic [POS_W-1:0]        particle_y;
	logic [POS_W-1:0]        neighbor_x;
	logic [POS_W-1:0]        neighbor_y;
	logic signed [ACC_W-1:0] accel_in_x;
	logic signed [ACC_W-1:0] accel_in_y;
	logic                    restart_stats;

	modport source (output valid, particle_x, particle_y, neighbor_x, neighbor_y,
		accel_in_x, accel_in_y, restart_stats, input ready);
	modport sink (input valid, particle_x, particle_y, neighbor_x, neighbor_y,
		accel_in_x, accel_in_y, restart_stats, output ready);
endinterface
`default_nettype wire

>>> rtl/core/srpf_out_if.sv
// Result channel of the pair force unit: updated acceleration and statistics.
// Depends on srpf_pkg.
`default_nettype none
interface srpf_out_if import srpf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] accel_out_x;
	logic signed [ACC_W-1:0] accel_out_y;
	logic                    in_range;
	logic [Q_W-1:0]          min_distance;
	logic [SUM_W-1:0]        distance_sum;
	logic [CNT_W-1:0]        pair_count;

	modport source (output valid, accel_out_x, accel_out_y, in_range, min_distance,
		distance_sum, pair_count, input ready);
	modport sink (input valid, accel_out_x, accel_out_y, in_range, min_distance,
		distance_sum, pair_count, output ready);
endinterface
`default_nettype wire

>>> rtl/core/srpf_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing but the clock.
`default_nettype none
module srpf_mul (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p
);
	logic [63:0] prod;

	assign prod = a * b;

	// product register
	always_ff @(posedge clk) begin
		p <= prod;
	end
endmodule
`default_nettype wire

>>> rtl/core/srpf_sqrt.sv
// Integer square root of a 64-bit value, one result bit per cycle.
// Standalone; used up to twice per pair by the top level.
`default_nettype none
module srpf_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] operand,
	output logic             done,
	output logic      [31:0] root
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic        done_q;
	logic [35:0] rem_t;
	logic [35:0] trial;
	logic        fit;

	assign rem_t = {rem_q, rad_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fit   = rem_t >= trial;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// two radicand bits per step
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (fit) begin
				rem_q  <= 34'(rem_t - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_t[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

>>> rtl/core/srpf_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// The caller gives the step count; ovf flags a quotient too wide for it.
// Depends on srpf_pkg.
`default_nettype none
module srpf_div import srpf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire div_req_t             req,
	input  wire logic [DIV_NUM_W-1:0] num,
	input  wire logic [DIV_DEN_W-1:0] den,
	output div_stat_t                 stat,
	output logic      [DIV_QUO_W-1:0] quo
);
	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic                 ovf_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] low_q;
	logic [DIV_QUO_W-1:0] quo_q;
	logic [DIV_NUM_W-1:0] head;
	logic [DIV_CNT_W:0]   low_sh;
	logic [DIV_DEN_W:0]   rem_t;
	logic                 fit;

	assign head   = num >> req.steps;
	assign low_sh = (DIV_CNT_W + 1)'(DIV_NUM_W) - {1'b0, req.steps};
	assign rem_t  = {rem_q, low_q[DIV_NUM_W-1]};
	assign fit    = rem_t >= {1'b0, den};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath; den is held by the caller for the whole run
	always_ff @(posedge clk) begin
		if (req.start) begin
			ovf_q <= head >= {{(DIV_NUM_W-DIV_DEN_W){1'b0}}, den};
			rem_q <= head[DIV_DEN_W-1:0];
			low_q <= num << low_sh;
			quo_q <= '0;
		end else if (busy_q) begin
			low_q <= {low_q[DIV_NUM_W-2:0], 1'b0};
			if (fit) begin
				rem_q <= DIV_DEN_W'(rem_t - {1'b0, den});
				quo_q <= {quo_q[DIV_QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_t[DIV_DEN_W-1:0];
				quo_q <= {quo_q[DIV_QUO_W-2:0], 1'b0};
			end
		end
	end

	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;
	assign quo       = quo_q;
endmodule
`default_nettype wire

>>> rtl/core/short_range_pair_force_unit.sv
// Top level of the short-range pair force unit: sequencer, registers,
// statistics. Uses srpf_pkg, srpf_in_if, srpf_out_if, srpf_mul, srpf_sqrt, srpf_div.
//
//   channel   dir  kind        moves
//   pair_in   in   valid/ready one particle pair per beat
//   result    out  valid/ready one result per pair
//   cfg_*     in   write only  cutoff, min radius, inverse mass
//
// A pair out of range goes from the range check straight to the result. In range,
// the 32-step square root runs up to twice, the divider takes FRAC_BITS+1 steps
// for the distance ratio and 48 steps for the force on each axis not skipped.
// pair_in.ready is high only when the sequencer is idle. A finished result
// sits in the output register while the next pair is taken.
// Reset is asynchronous, active low; configuration registers take their default values.
`default_nettype none
module short_range_pair_force_unit import srpf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [POS_W-1:0]     cfg_wdata,
	srpf_in_if.sink                   pair_in,
	srpf_out_if.source                result
);
	typedef enum logic [18:0] {
		ST_IDLE = 19'h00001,
		ST_MSX  = 19'h00002,
		ST_MSY  = 19'h00004,
		ST_MC2  = 19'h00008,
		ST_MM2  = 19'h00010,
		ST_CHK  = 19'h00020,
		ST_RC2  = 19'h00040,
		ST_SQ1  = 19'h00080,
		ST_SQ2  = 19'h00100,
		ST_DVQ  = 19'h00200,
		ST_DEN0 = 19'h00400,
		ST_DEN1 = 19'h00800,
		ST_DEN2 = 19'h01000,
		ST_AX0  = 19'h02000,
		ST_AX1  = 19'h04000,
		ST_AX2  = 19'h08000,
		ST_AX3  = 19'h10000,
		ST_AX4  = 19'h20000,
		ST_DONE = 19'h40000
	} state_t;

	state_t state_q;

	logic [POS_W-1:0] cut_q, minr_q, invm_q;

	logic [POS_W-1:0]        adx_q, ady_q;
	logic                    dxneg_q, dyneg_q;
	logic signed [ACC_W-1:0] accx_q, accy_q;
	logic [63:0]             sx_q, sy_q, c2_q, m2_q, r2_q, rc2_q;
	logic                    inr_q;
	logic [31:0]             r_q;
	logic [63:0]             den_lo_q;
	logic [DIV_DEN_W-1:0]    den_q;
	logic [63:0]             p1_q;
	logic [63:0]             prod_lo_q;
	logic                    axis_q;
	logic [Q_W-1:0]          mind_q;
	logic [SUM_W-1:0]        dsum_q;
	logic [CNT_W-1:0]        pcnt_q;

	logic                    out_valid_q;
	logic signed [ACC_W-1:0] out_ax_q, out_ay_q;
	logic                    out_inr_q;
	logic [Q_W-1:0]          out_mind_q;
	logic [SUM_W-1:0]        out_dsum_q;
	logic [CNT_W-1:0]        out_pcnt_q;

	// shared units
	logic [31:0]          mul_a, mul_b;
	logic [63:0]          mul_p;
	logic                 sq_start;
	logic [63:0]          sq_op;
	logic                 sq_done;
	logic [31:0]          sq_root;
	div_req_t             dv_req;
	logic [DIV_NUM_W-1:0] dv_num;
	logic [DIV_DEN_W-1:0] dv_den;
	div_stat_t            dv_stat;
	logic [DIV_QUO_W-1:0] dv_quo;

	// ratio division runs on the cutoff, force division on r * rc2
	assign dv_den = (state_q == ST_SQ2 || state_q == ST_DVQ) ? DIV_DEN_W'(cut_q) : den_q;

	srpf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	srpf_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sq_start), .operand(sq_op),
		.done(sq_done), .root(sq_root));

	srpf_div u_div (.clk(clk), .arst_n(arst_n), .req(dv_req), .num(dv_num), .den(dv_den),
		.stat(dv_stat), .quo(dv_quo));

	// separation magnitudes at the input beat
	logic [POS_W:0] dx, dy;
	logic           accept;
	assign dx     = {1'b0, pair_in.neighbor_x} - {1'b0, pair_in.particle_x};
	assign dy     = {1'b0, pair_in.neighbor_y} - {1'b0, pair_in.particle_y};
	assign accept = pair_in.valid && pair_in.ready;
	assign pair_in.ready = state_q == ST_IDLE;

	// per-axis operands
	logic [POS_W-1:0]        ad, gap;
	logic                    dneg, fneg, skip;
	logic signed [ACC_W-1:0] acc_sel;
	assign ad      = axis_q ? ady_q : adx_q;
	assign dneg    = axis_q ? dyneg_q : dxneg_q;
	assign acc_sel = axis_q ? accy_q : accx_q;
	assign gap     = (r_q >= cut_q) ? r_q - cut_q : cut_q - r_q;
	assign fneg    = (r_q < cut_q) != dneg;
	assign skip    = (r_q == '0) || (gap == '0) || (ad == '0) || (invm_q == '0);

	// range check and clamp
	logic [63:0] c2_left, rc2_sel;
	logic        in_rng;
	assign c2_left = c2_q - sx_q;
	assign in_rng  = (sx_q <= c2_q) && (sy_q <= c2_left);
	assign rc2_sel = (r2_q > m2_q) ? r2_q : m2_q;

	// force numerator from the two product halves
	logic [DIV_DEN_W-1:0] prod96;
	assign prod96 = {mul_p, 32'b0} + {32'b0, prod_lo_q};

	// force magnitude and saturating accumulate
	logic [ACC_W-1:0]     mag;
	logic signed [ACC_W:0] acc_ext, mag_ext, acc_sum;
	logic signed [ACC_W-1:0] acc_new;
	assign mag     = (dv_stat.ovf || dv_quo > MAG_CAP) ? MAG_CAP[ACC_W-1:0]
	                                                    : dv_quo[ACC_W-1:0];
	assign acc_ext = {acc_sel[ACC_W-1], acc_sel};
	assign mag_ext = {1'b0, mag};
	assign acc_sum = fneg ? acc_ext - mag_ext : acc_ext + mag_ext;
	always_comb begin
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
			acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			acc_new = acc_sum[ACC_W-1:0];
	end

	// statistics update from the distance ratio
	logic [Q_W-1:0]   q_val;
	logic [SUM_W:0]   dsum_t;
	assign q_val  = dv_quo[Q_W-1:0];
	assign dsum_t = {1'b0, dsum_q} + (SUM_W + 1)'(q_val);

	// unit operand select
	always_comb begin
		mul_a        = '0;
		mul_b        = '0;
		sq_start     = 1'b0;
		sq_op        = r2_q;
		dv_req.start = 1'b0;
		dv_req.steps = FORCE_STEPS;
		dv_num       = {32'b0, prod96} << FRAC_BITS;
		unique case (state_q)
			ST_MSX: begin mul_a = adx_q; mul_b = adx_q; end
			ST_MSY: begin mul_a = ady_q; mul_b = ady_q; end
			ST_MC2: begin mul_a = cut_q; mul_b = cut_q; end
			ST_MM2: begin mul_a = minr_q; mul_b = minr_q; end
			ST_RC2: begin
				sq_start = 1'b1;
				sq_op    = rc2_sel;
			end
			ST_SQ1: sq_start = sq_done && (r2_q != '0);
			ST_SQ2: begin
				dv_req.start = sq_done;
				dv_req.steps = RATIO_STEPS;
				dv_num       = {96'b0, sq_root} << FRAC_BITS;
			end
			ST_DEN0: begin mul_a = r_q; mul_b = rc2_q[31:0]; end
			ST_DEN1: begin mul_a = r_q; mul_b = rc2_q[63:32]; end
			ST_AX0: begin mul_a = gap; mul_b = ad; end
			ST_AX1: begin mul_a = mul_p[31:0]; mul_b = invm_q; end
			ST_AX2: begin mul_a = p1_q[63:32]; mul_b = invm_q; end
			ST_AX3: dv_req.start = 1'b1;
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q  <= CUTOFF_RESET;
			minr_q <= MIN_R_RESET;
			invm_q <= INV_M_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CUTOFF:   cut_q  <= cfg_wdata;
				REG_MIN_R:    minr_q <= cfg_wdata;
				REG_INV_MASS: invm_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			inr_q       <= 1'b0;
			mind_q      <= Q_W'(1) << FRAC_BITS;
			dsum_q      <= '0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// ST_DONE handles the output beat on its own
			if (out_valid_q && result.ready && state_q != ST_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						axis_q  <= 1'b0;
						inr_q   <= 1'b0;
						state_q <= ST_MSX;
						if (pair_in.restart_stats) begin
							mind_q <= Q_W'(1) << FRAC_BITS;
							dsum_q <= '0;
							pcnt_q <= '0;
						end
					end
				end
				ST_MSX: state_q <= ST_MSY;
				ST_MSY: state_q <= ST_MC2;
				ST_MC2: state_q <= ST_MM2;
				ST_MM2: state_q <= ST_CHK;
				ST_CHK: begin
					inr_q   <= in_rng;
					state_q <= in_rng ? ST_RC2 : ST_DONE;
				end
				ST_RC2: state_q <= ST_SQ1;
				ST_SQ1: begin
					if (sq_done)
						state_q <= (r2_q != '0) ? ST_SQ2 : ST_DEN0;
				end
				ST_SQ2: begin
					if (sq_done)
						state_q <= ST_DVQ;
				end
				ST_DVQ: begin
					if (dv_stat.done) begin
						if (q_val < mind_q)
							mind_q <= q_val;
						dsum_q <= dsum_t[SUM_W] ? '1 : dsum_t[SUM_W-1:0];
						if (pcnt_q != '1)
							pcnt_q <= pcnt_q + 1'b1;
						state_q <= ST_DEN0;
					end
				end
				ST_DEN0: state_q <= ST_DEN1;
				ST_DEN1: state_q <= ST_DEN2;
				ST_DEN2: state_q <= ST_AX0;
				ST_AX0: begin
					if (!skip)
						state_q <= ST_AX1;
					else if (!axis_q)
						axis_q <= 1'b1;
					else
						state_q <= ST_DONE;
				end
				ST_AX1: state_q <= ST_AX2;
				ST_AX2: state_q <= ST_AX3;
				ST_AX3: state_q <= ST_AX4;
				ST_AX4: begin
					if (dv_stat.done) begin
						if (!axis_q) begin
							axis_q  <= 1'b1;
							state_q <= ST_AX0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					adx_q   <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
					ady_q   <= dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
					dxneg_q <= dx[POS_W];
					dyneg_q <= dy[POS_W];
					accx_q  <= pair_in.accel_in_x;
					accy_q  <= pair_in.accel_in_y;
				end
			end
			ST_MSY: sx_q <= mul_p;
			ST_MC2: sy_q <= mul_p;
			ST_MM2: c2_q <= mul_p;
			ST_CHK: begin
				m2_q <= mul_p;
				r2_q <= sx_q + sy_q;
			end
			ST_RC2: rc2_q <= rc2_sel;
			ST_SQ1: if (sq_done) r_q <= sq_root;
			ST_DEN1: den_lo_q <= mul_p;
			ST_DEN2: den_q <= {mul_p, 32'b0} + {32'b0, den_lo_q};
			ST_AX1: p1_q <= mul_p;
			ST_AX2: prod_lo_q <= mul_p;
			ST_AX4: begin
				if (dv_stat.done) begin
					if (axis_q) accy_q <= acc_new;
					else        accx_q <= acc_new;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					out_ax_q   <= accx_q;
					out_ay_q   <= accy_q;
					out_inr_q  <= inr_q;
					out_mind_q <= mind_q;
					out_dsum_q <= dsum_q;
					out_pcnt_q <= pcnt_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid        = out_valid_q;
	assign result.accel_out_x  = out_ax_q;
	assign result.accel_out_y  = out_ay_q;
	assign result.in_range     = out_inr_q;
	assign result.min_distance = out_mind_q;
	assign result.distance_sum = out_dsum_q;
	assign result.pair_count   = out_pcnt_q;
endmodule
`default_nettype wire
